### hw/rtl/three_phase_dq_transform_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dq transform unit
// Clocked checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_DQ_TRANSFORM_UNIT_DEFINES_SVH
`define THREE_PHASE_DQ_TRANSFORM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// check prop on every edge out of reset
`define DQT_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
		else $error("dqt assertion failed");

// check prop on every edge while reset is held
`define DQT_ASSERT_IN_RST(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) !rst_ni |-> prop) \
		else $error("dqt reset assertion failed");

`else

`define DQT_ASSERT(lbl, clk_i, rst_ni, prop)
`define DQT_ASSERT_IN_RST(lbl, clk_i, rst_ni, prop)

`endif

`endif

### hw/rtl/dqt_pkg.sv
// ----------------------------------------------------------------------------
// dqt_pkg
// Types and fixed-point constants shared by the dq transform unit.
// ----------------------------------------------------------------------------
package dqt_pkg;

	localparam int PHASE_W = 16;
	localparam int Z_W     = 15;
	localparam int COEF_W  = 18;

	// stages from input register to output register
	localparam int PIPE_DEPTH = 9;

	localparam logic [PHASE_W-1:0] PHASE_THIRD  = 16'd21845;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;
	localparam logic [Z_W-1:0]     Z_ONE        = 15'd16384;

	localparam logic [16:0] POLY_A          = 17'd102944;
	localparam logic [15:0] POLY_B          = 16'd42047;
	localparam logic [12:0] POLY_C          = 13'd4639;
	localparam logic [14:0] SQRT_TWO_THIRDS = 15'd26755;

	// folded quadrant argument of one sine evaluation
	typedef struct packed {
		logic           neg;
		logic [Z_W-1:0] z;
	} sine_arg_t;

	function automatic sine_arg_t fold_phase(logic [PHASE_W-1:0] p);
		sine_arg_t a;
		a.neg = p[15];
		if (p[14]) begin
			a.z = Z_ONE - {1'b0, p[13:0]};
		end else begin
			a.z = {1'b0, p[13:0]};
		end
		return a;
	endfunction

endpackage

### hw/rtl/dqt_sine.sv
// ----------------------------------------------------------------------------
// dqt_sine
// Pipelined polynomial sine, scaled by sqrt(2/3), one multiply per stage.
// ----------------------------------------------------------------------------
module dqt_sine (
	input  logic                                clk,
	input  logic                                ce,
	input  dqt_pkg::sine_arg_t                  arg_s1,
	output logic signed [dqt_pkg::COEF_W-1:0]   coef_s6
);

	logic [dqt_pkg::Z_W-1:0] z_s2, z_s3, z_s4;
	logic                    neg_s2, neg_s3, neg_s4, neg_s5;
	logic [14:0]             z2_s2, z2_s3;
	logic [12:0]             t_s3;
	logic [16:0]             u_s4;
	logic [17:0]             s_s5;

	logic [28:0] sq_p;
	logic [26:0] t_p;
	logic [15:0] u_diff;
	logic [30:0] u_p;
	logic [16:0] s_diff;
	logic [31:0] s_p;
	logic [32:0] m_p;
	logic [16:0] m_mag;

	always_comb begin
		sq_p   = 29'(arg_s1.z) * 29'(arg_s1.z);
		t_p    = 27'(dqt_pkg::POLY_C) * 27'(z2_s2);
		u_diff = dqt_pkg::POLY_B - {3'b0, t_s3};
		u_p    = 31'(u_diff) * 31'(z2_s3);
		s_diff = dqt_pkg::POLY_A - u_s4;
		s_p    = 32'(s_diff) * 32'(z_s4);
		m_p    = 33'(s_s5) * 33'(dqt_pkg::SQRT_TWO_THIRDS);
		m_mag  = m_p[32:16];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			z_s2    <= arg_s1.z;
			neg_s2  <= arg_s1.neg;
			z2_s2   <= sq_p[28:14];

			z_s3    <= z_s2;
			neg_s3  <= neg_s2;
			z2_s3   <= z2_s2;
			t_s3    <= t_p[26:14];

			z_s4    <= z_s3;
			neg_s4  <= neg_s3;
			u_s4    <= u_p[30:14];

			neg_s5  <= neg_s4;
			s_s5    <= s_p[31:14];

			// apply the quadrant sign after scaling
			if (neg_s5) begin
				coef_s6 <= -$signed({1'b0, m_mag});
			end else begin
				coef_s6 <= $signed({1'b0, m_mag});
			end
		end
	end

endmodule

### hw/rtl/three_phase_dq_transform_unit.sv
// ----------------------------------------------------------------------------
// three_phase_dq_transform_unit
// Power-invariant abc to dq transform of two phase currents and an angle.
//
//  port group | dir | item contents
//  s_axis     | in  | U current, V current, electrical angle
//  m_axis     | out | d current, q current
//
// Accepts one item per cycle while no result is stalled at the output;
// each result passes the input register, the five-multiply sine pipeline
// in dqt_sine, the current products, the sums and the rounding stage.
// arst_n clears the stage valid bits only; payload registers are not reset.
// m_axis_tready low while a result waits at the output freezes every stage
// and drops s_axis_tready in the same cycle, so a stall holds all items in
// place; with the output stage empty the pipeline keeps advancing.
// ----------------------------------------------------------------------------
`include "three_phase_dq_transform_unit_defines.svh"

module three_phase_dq_transform_unit #(
	parameter int ANGLE_BITS   = 14,
	parameter int CURRENT_BITS = 16,
	localparam int IN_W  = ((2 * CURRENT_BITS + ANGLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * CURRENT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,

	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// phase_u_current, phase_v_current, elec_angle (from bit 0 up)
	input  logic [IN_W-1:0]  s_axis_tdata,

	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// direct_current, quadrature_current (from bit 0 up)
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int CB     = CURRENT_BITS;
	localparam int CUR_W  = CB + 2;
	localparam int PROD_W = CUR_W + dqt_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int R_W    = ACC_W - 15;
	localparam int NSTG   = dqt_pkg::PIPE_DEPTH;

	localparam logic [R_W-1:0]   LIM_POS    = R_W'((1 << (CB - 1)) - 1);
	localparam logic [R_W-1:0]   LIM_NEG    = R_W'(1 << (CB - 1));
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);

	logic                ce;
	logic [NSTG-1:0]     vld_q;

	logic signed [CB-1:0]    u_in, v_in;
	logic signed [CUR_W-1:0] u_x, v_x, w_x;
	logic [ANGLE_BITS-1:0]   angle_in;
	logic [dqt_pkg::PHASE_W-1:0] theta;
	logic [dqt_pkg::PHASE_W-1:0] ph [3];

	dqt_pkg::sine_arg_t arg_cos_s1 [3];
	dqt_pkg::sine_arg_t arg_sin_s1 [3];

	logic signed [CUR_W-1:0] cur_s1 [3];
	logic signed [CUR_W-1:0] cur_s2 [3];
	logic signed [CUR_W-1:0] cur_s3 [3];
	logic signed [CUR_W-1:0] cur_s4 [3];
	logic signed [CUR_W-1:0] cur_s5 [3];
	logic signed [CUR_W-1:0] cur_s6 [3];

	logic signed [dqt_pkg::COEF_W-1:0] cos_coef [3];
	logic signed [dqt_pkg::COEF_W-1:0] sin_coef [3];

	logic signed [PROD_W-1:0] prod_d_s7 [3];
	logic signed [PROD_W-1:0] prod_q_s7 [3];
	logic signed [ACC_W-1:0]  acc_d_s8, acc_q_s8;
	logic [CB-1:0]            res_d_s9, res_q_s9;

	function automatic logic [CB-1:0] round_sat(logic signed [ACC_W-1:0] acc);
		logic             neg;
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] sum;
		logic [R_W-1:0]   r;
		logic [R_W-1:0]   rn;
		neg = acc[ACC_W-1];
		mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
		sum = mag + ROUND_HALF;
		r   = sum[ACC_W-1:15];
		if (neg) begin
			if (r > LIM_NEG) begin
				r = LIM_NEG;
			end
			rn = -r;
			return rn[CB-1:0];
		end
		if (r > LIM_POS) begin
			r = LIM_POS;
		end
		return r[CB-1:0];
	endfunction

	// whole pipeline advances unless a finished result is stuck at the output
	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;
	assign m_axis_tvalid = vld_q[NSTG-1];
	assign m_axis_tdata  = OUT_W'({res_q_s9, res_d_s9});

	always_comb begin
		u_in     = $signed(s_axis_tdata[CB-1:0]);
		v_in     = $signed(s_axis_tdata[2*CB-1:CB]);
		angle_in = s_axis_tdata[2*CB +: ANGLE_BITS];
		u_x      = CUR_W'(u_in);
		v_x      = CUR_W'(v_in);
		w_x      = -(u_x + v_x);
		theta    = dqt_pkg::PHASE_W'(32'(angle_in) << (dqt_pkg::PHASE_W - ANGLE_BITS));
		ph[0]    = theta;
		ph[1]    = theta - dqt_pkg::PHASE_THIRD;
		ph[2]    = theta + dqt_pkg::PHASE_THIRD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < 3; k++) begin
				arg_cos_s1[k] <= dqt_pkg::fold_phase(ph[k] + dqt_pkg::QUARTER_TURN);
				arg_sin_s1[k] <= dqt_pkg::fold_phase(ph[k]);
			end
			cur_s1[0] <= u_x;
			cur_s1[1] <= v_x;
			cur_s1[2] <= w_x;

			// carry currents alongside the sine pipeline
			cur_s2 <= cur_s1;
			cur_s3 <= cur_s2;
			cur_s4 <= cur_s3;
			cur_s5 <= cur_s4;
			cur_s6 <= cur_s5;

			for (int k = 0; k < 3; k++) begin
				prod_d_s7[k] <= PROD_W'(cur_s6[k]) * PROD_W'(cos_coef[k]);
				prod_q_s7[k] <= PROD_W'(cur_s6[k]) * PROD_W'(sin_coef[k]);
			end

			acc_d_s8 <= ACC_W'(prod_d_s7[0]) + ACC_W'(prod_d_s7[1])
				+ ACC_W'(prod_d_s7[2]);
			acc_q_s8 <= -(ACC_W'(prod_q_s7[0]) + ACC_W'(prod_q_s7[1])
				+ ACC_W'(prod_q_s7[2]));

			res_d_s9 <= round_sat(acc_d_s8);
			res_q_s9 <= round_sat(acc_q_s8);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_phase
		dqt_sine u_cos (
			.clk     (clk),
			.ce      (ce),
			.arg_s1  (arg_cos_s1[k]),
			.coef_s6 (cos_coef[k])
		);

		dqt_sine u_sin (
			.clk     (clk),
			.ce      (ce),
			.arg_s1  (arg_sin_s1[k]),
			.coef_s6 (sin_coef[k])
		);
	end

	`DQT_ASSERT(a_enter, clk, arst_n, ce && s_axis_tvalid |=> vld_q[0])
	`DQT_ASSERT(a_bubble, clk, arst_n, ce && !s_axis_tvalid |=> !vld_q[0])
	`DQT_ASSERT(a_freeze, clk, arst_n, !ce |=> $stable(vld_q))
	`DQT_ASSERT_IN_RST(a_rst_empty, clk, arst_n, vld_q == '0)

endmodule

### tb/three_phase_dq_transform_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_dq_transform_unit_tb
// Streams phase current and angle items through the dq transform unit and
// checks every d/q result against an in-bench fixed-point predictor or the
// expected pair in its directed row. A short directed table covers extremes
// and quadrant edges; random items follow, with random idling on both stream
// sides, one long output hold-off and one drain pause on the input side.
// ----------------------------------------------------------------------------
module three_phase_dq_transform_unit_tb;

	localparam int IN_W         = 48;
	localparam int OUT_W        = 32;
	localparam int RANDOM_ITEMS = 900;
	localparam int LIMIT_CYCLES = 200000;

	// sine polynomial and scale, Q14 argument, Q16 sine, Q15 scaled result
	localparam longint SIN_K1     = 102944;
	localparam longint SIN_K3     = 42047;
	localparam longint SIN_K5     = 4639;
	localparam longint ROOT_2_3   = 26755;
	localparam logic [15:0] THIRD_TURN = 16'd21845;
	localparam logic [15:0] QTR_TURN   = 16'd16384;

	typedef struct packed {
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic [13:0]        angle;
		logic               known;
		logic signed [15:0] d;
		logic signed [15:0] q;
	} dq_row_t;

	typedef struct packed {
		logic signed [15:0] d;
		logic signed [15:0] q;
	} dq_pair_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	dq_pair_t pending_dq[$];
	dq_row_t  directed_rows [0:19];
	int       items_sent;
	int       err_count;
	int       cycle_count;

	three_phase_dq_transform_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// scaled sine of a 16-bit phase, sqrt(2/3) folded in, Q15
	function automatic longint sine_coef(input logic [15:0] ph);
		longint z, z2, t, w, s, m;
		z = longint'(ph[13:0]);
		if (ph[14]) begin
			z = 16384 - z;
		end
		z2 = (z * z) >> 14;
		t  = (SIN_K5 * z2) >> 14;
		w  = ((SIN_K3 - t) * z2) >> 14;
		s  = ((SIN_K1 - w) * z) >> 14;
		m  = (s * ROOT_2_3) >> 16;
		return ph[15] ? -m : m;
	endfunction

	// round magnitude half away from zero, clamp to signed 16 bits
	function automatic logic [15:0] round_clamp16(input longint acc);
		longint mag, r;
		mag = (acc < 0) ? -acc : acc;
		r = (mag + 16384) >> 15;
		if (acc < 0) begin
			if (r > 32768) begin
				r = 32768;
			end
			return 16'(-r);
		end
		if (r > 32767) begin
			r = 32767;
		end
		return 16'(r);
	endfunction

	function automatic dq_pair_t predict_dq(input logic signed [15:0] u,
			input logic signed [15:0] v, input logic [13:0] angle);
		longint   cur [3];
		logic [15:0] th;
		logic [15:0] ph [3];
		longint   dacc, qacc;
		dq_pair_t res;
		cur[0] = u;
		cur[1] = v;
		cur[2] = -(cur[0] + cur[1]);
		th = {angle, 2'b00};
		ph[0] = th;
		ph[1] = th - THIRD_TURN;
		ph[2] = th + THIRD_TURN;
		dacc = 0;
		qacc = 0;
		for (int k = 0; k < 3; k++) begin
			dacc += cur[k] * sine_coef(ph[k] + QTR_TURN);
			qacc -= cur[k] * sine_coef(ph[k]);
		end
		res.d = round_clamp16(dacc);
		res.q = round_clamp16(qacc);
		return res;
	endfunction

	function automatic logic [15:0] pick_current();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 16'($urandom);
		end else if (r == 6) begin
			return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
		end else if (r == 7) begin
			return 16'($urandom_range(0, 64) - 32);
		end else if (r == 8) begin
			return 16'($urandom_range(24000, 32767) * (($urandom_range(0, 1) != 0) ? 1 : -1));
		end
		return 16'($urandom_range(0, 2000) - 1000);
	endfunction

	function automatic logic [13:0] pick_angle();
		if ($urandom_range(0, 9) < 8) begin
			return 14'($urandom_range(0, 16383));
		end
		// land near a quadrant edge
		return 14'($urandom_range(0, 3) * 4096 + $urandom_range(0, 6) - 3);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (items_sent >= 150 && items_sent < 250) begin
			return 0;
		end
		if (r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// offer one item from a negedge, return at a negedge after acceptance and any idle gap
	task automatic send_item(input dq_row_t row);
		dq_pair_t exp_dq;
		int gap;
		s_axis_tdata  <= {2'b00, row.angle, row.v, row.u};
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		if (row.known) begin
			exp_dq.d = row.d;
			exp_dq.q = row.q;
		end else begin
			exp_dq = predict_dq(row.u, row.v, row.angle);
		end
		pending_dq = {pending_dq, exp_dq};
		items_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		dq_pair_t exp_dq;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_dq.size() == 0) begin
				$error("result item with no pending expectation: d=%0d q=%0d",
					$signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
				err_count++;
			end else begin
				exp_dq = pending_dq.pop_front();
				if (m_axis_tdata[15:0] !== exp_dq.d) begin
					$error("direct_current: expected %0d, got %0d",
						exp_dq.d, $signed(m_axis_tdata[15:0]));
					err_count++;
				end
				if (m_axis_tdata[31:16] !== exp_dq.q) begin
					$error("quadrature_current: expected %0d, got %0d",
						exp_dq.q, $signed(m_axis_tdata[31:16]));
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// output side: random stalls, a no-stall stretch and one long hold-off
	initial begin
		bit held;
		int r, n;
		logic lvl;
		held = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && items_sent >= 350) begin
				held = 1'b1;
				lvl = 1'b0;
				n = 80;
			end else if (items_sent >= 150 && items_sent < 250) begin
				lvl = 1'b1;
				n = 1;
			end else if (r < 70) begin
				lvl = 1'b1;
				n = $urandom_range(1, 20);
			end else if (r < 95) begin
				lvl = 1'b0;
				n = $urandom_range(1, 3);
			end else begin
				lvl = 1'b0;
				n = $urandom_range(10, 40);
			end
			m_axis_tready <= lvl;
			repeat (n) @(negedge clk);
		end
	end

	initial begin
		dq_row_t row;
		items_sent    = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		directed_rows = '{
			'{16'sd0,      16'sd0,      14'd0,     1'b1, 16'sd0,      16'sd0},
			'{16'sd0,      16'sd0,      14'd16383, 1'b1, 16'sd0,      16'sd0},
			'{16'sd32767,  16'sd32767,  14'd0,     1'b1, 16'sd32767,  16'sd32767},
			'{-16'sd32768, -16'sd32768, 14'd0,     1'b1, -16'sd32768, -16'sd32768},
			'{16'sd1000,   16'sd0,      14'd0,     1'b0, 16'sd0,      16'sd0},
			'{16'sd1000,   -16'sd500,   14'd4096,  1'b0, 16'sd0,      16'sd0},
			'{16'sd1000,   -16'sd500,   14'd8192,  1'b0, 16'sd0,      16'sd0},
			'{16'sd1000,   -16'sd500,   14'd12288, 1'b0, 16'sd0,      16'sd0},
			'{16'sd1000,   -16'sd500,   14'd16383, 1'b0, 16'sd0,      16'sd0},
			'{16'sd1,      16'sd0,      14'd0,     1'b0, 16'sd0,      16'sd0},
			'{-16'sd1,     16'sd0,      14'd0,     1'b0, 16'sd0,      16'sd0},
			'{16'sd0,      16'sd1,      14'd5461,  1'b0, 16'sd0,      16'sd0},
			'{16'sd0,      -16'sd1,     14'd10923, 1'b0, 16'sd0,      16'sd0},
			'{16'sd32767,  -16'sd32768, 14'd4096,  1'b0, 16'sd0,      16'sd0},
			'{-16'sd32768, 16'sd32767,  14'd8192,  1'b0, 16'sd0,      16'sd0},
			'{-16'sd32768, -16'sd32768, 14'd8192,  1'b0, 16'sd0,      16'sd0},
			'{16'sd16384,  16'sd16384,  14'd2048,  1'b0, 16'sd0,      16'sd0},
			'{-16'sd12345, 16'sd6789,   14'd12000, 1'b0, 16'sd0,      16'sd0},
			'{16'sd32767,  16'sd0,      14'd1,     1'b0, 16'sd0,      16'sd0},
			'{16'sd0,      16'sd32767,  14'd16382, 1'b0, 16'sd0,      16'sd0}
		};
		// assert reset once every process is waiting on it
		#1 arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// hold the input once until the pipeline has drained
			if (i == 500) begin
				s_axis_tvalid <= 1'b0;
				while (pending_dq.size() != 0) @(negedge clk);
			end
			row.u     = pick_current();
			row.v     = pick_current();
			row.angle = pick_angle();
			row.known = 1'b0;
			row.d     = '0;
			row.q     = '0;
			send_item(row);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_dq.size() != 0) @(negedge clk);
		repeat (dqt_pkg::PIPE_DEPTH + 4) @(negedge clk);
		if (err_count == 0 && pending_dq.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
